@@ hw/rtl/ptku_pkg.sv @@
`default_nettype none

package ptku_pkg;

    // Fixed-point format and angle constants
    localparam int    FRAC_BITS = 16;
    localparam longint PI_Q32   = 64'sd13493037705;
    localparam int    PI_Q      = int'((PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS)))
                                       >>> (32 - FRAC_BITS));
    localparam int    TWO_PI_Q  = 2 * PI_Q;

    // Field widths
    localparam int REG_W  = 22;
    localparam int RNG_W  = 23;
    localparam int ANG_W  = 21;
    localparam int VAR_W  = 22;
    localparam int SHR_W  = 21;
    localparam int SHA_W  = 19;
    localparam int MRNG_W = 22;

    // Datapath widths
    localparam int X_W    = 24;
    localparam int P_W    = 23;
    localparam int S_W    = 24;
    localparam int MAG_W  = 24;
    localparam int PROD_W = 47;
    localparam int NUM_W  = 48;
    localparam int QUO_W  = 24;
    localparam int WRAP_W = 24;

    // Output limits
    localparam int RANGE_LIM = 2621440;
    localparam int ANGLE_LIM = 823550;

    // Register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_RANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ANGLE = 3'd5;

    localparam logic [REG_W-1:0] RST_PROC_RANGE = 22'd6554;
    localparam logic [REG_W-1:0] RST_PROC_ANGLE = 22'd1144;
    localparam logic [REG_W-1:0] RST_MEAS_RANGE = 22'd6554;
    localparam logic [REG_W-1:0] RST_MEAS_ANGLE = 22'd1144;
    localparam logic [REG_W-1:0] RST_GATE_RANGE = 22'd32768;
    localparam logic [REG_W-1:0] RST_GATE_ANGLE = 22'd5719;

    // Wrap an angle into (-pi, pi]: try each whole number of turns from -3 to +3 in parallel
    function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
        logic signed [WRAP_W-1:0] cand;
        logic signed [ANG_W-1:0]  res;
        res  = a;
        cand = '0;
        for (int k = -3; k <= 3; k++) begin
            cand = WRAP_W'(a) + WRAP_W'(k * TWO_PI_Q);
            if (cand > WRAP_W'(-PI_Q) && cand <= WRAP_W'(PI_Q)) begin
                res = ANG_W'(cand);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/polar_track_kalman_update.sv @@
`default_nettype none

// Channel   Dir  tdata bits  tuser  Contents
// s_axis    in   176         -      one track: prior, variances, shifts, measurement
// m_axis    out  88          1      updated track and keep flag
// cfg       in   22          -      noise and gate registers, write only
//
// One track per cycle while the sink stays ready; a track passes through the 24 stages
// of the pipelined dividers plus 6 datapath stages.
// Reset (aresetn low, synchronous) empties the pipeline and restores the registers.
// Each stage holds while its successor is full and stalled; bubbles close up,
// so input is taken whenever any stage ahead has room.
module polar_track_kalman_update (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // prior_range[22:0] prior_angle[43:23] prior_var_range[65:44]
    // prior_var_angle[87:66] shift_range[108:88] shift_angle[127:109]
    // meas_range[149:128] meas_angle[170:150], zero fill [175:171]
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [175:0]                s_tdata,
    // post_range[22:0] post_angle[43:23] post_var_range[65:44] post_var_angle[87:66]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [87:0]                      m_tdata,
    // keep[0]
    output logic                             m_tuser,
    input  wire logic                        cfg_we,
    input  wire logic [ptku_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [ptku_pkg::REG_W-1:0]  cfg_wdata
);

    import ptku_pkg::*;

    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_C  = 2;
    localparam int ST_D  = 3;
    localparam int ST_DV = 4;
    localparam int ST_E  = ST_DV + QUO_W;
    localparam int ST_F  = ST_E + 1;
    localparam int NS    = ST_F + 1;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [P_W-1:0]        p;
        logic                  neg;
        logic                  szero;
    } axis_t;

    typedef struct packed {
        axis_t r;
        axis_t a;
        logic  have;
    } side_t;

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] q_r_reg, q_a_reg, r_r_reg, r_a_reg, g_r_reg, g_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_r_reg <= RST_PROC_RANGE;
            q_a_reg <= RST_PROC_ANGLE;
            r_r_reg <= RST_MEAS_RANGE;
            r_a_reg <= RST_MEAS_ANGLE;
            g_r_reg <= RST_GATE_RANGE;
            g_a_reg <= RST_GATE_ANGLE;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PROC_RANGE: q_r_reg <= cfg_wdata;
                REG_PROC_ANGLE: q_a_reg <= cfg_wdata;
                REG_MEAS_RANGE: r_r_reg <= cfg_wdata;
                REG_MEAS_ANGLE: r_a_reg <= cfg_wdata;
                REG_GATE_RANGE: g_r_reg <= cfg_wdata;
                REG_GATE_ANGLE: g_a_reg <= cfg_wdata;
                default: ;  // drop writes beyond the map
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // A stage may load when it is empty or its content moves on
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[ST_A];

    // ---------------- stage A: unpack, wrap angles, predict ----------------
    logic signed [RNG_W-1:0]  in_pr;
    logic signed [ANG_W-1:0]  in_pa;
    logic [VAR_W-1:0]         in_pvr, in_pva;
    logic signed [SHR_W-1:0]  in_sr;
    logic signed [SHA_W-1:0]  in_sa;
    logic signed [MRNG_W-1:0] in_mr;
    logic signed [ANG_W-1:0]  in_ma;

    assign in_pr  = s_tdata[22:0];
    assign in_pa  = s_tdata[43:23];
    assign in_pvr = s_tdata[65:44];
    assign in_pva = s_tdata[87:66];
    assign in_sr  = s_tdata[108:88];
    assign in_sa  = s_tdata[127:109];
    assign in_mr  = s_tdata[149:128];
    assign in_ma  = s_tdata[170:150];

    logic signed [X_W-1:0]    a_xr_reg;
    logic signed [ANG_W-1:0]  a_xa_reg;
    logic signed [SHA_W-1:0]  a_sa_reg;
    logic signed [MRNG_W-1:0] a_zr_reg;
    logic signed [ANG_W-1:0]  a_za_reg;
    logic [P_W-1:0]           a_pr_reg, a_pa_reg;
    logic                     a_have_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_A]) begin
            a_xr_reg   <= X_W'(in_pr) + X_W'(in_sr);
            a_xa_reg   <= wrap_angle(in_pa);
            a_sa_reg   <= in_sa;
            a_zr_reg   <= in_mr;
            a_za_reg   <= wrap_angle(in_ma);
            a_pr_reg   <= P_W'(in_pvr) + P_W'(q_r_reg);
            a_pa_reg   <= P_W'(in_pva) + P_W'(q_a_reg);
            a_have_reg <= in_mr > MRNG_W'(0);
        end
    end

    // ---------------- stage B: innovation and its denominator ----------------
    side_t            b_side_reg;
    logic [MAG_W-1:0] b_mag_r_reg, b_mag_a_reg;
    logic [S_W-1:0]   b_s_r_reg, b_s_a_reg;

    logic signed [X_W-1:0] b_xa;
    logic signed [X_W:0]   b_yr, b_ya;
    logic [S_W-1:0]        b_sr, b_sa;

    always_comb begin
        b_xa = X_W'(a_xa_reg) + X_W'(a_sa_reg);
        b_yr = (X_W+1)'(a_zr_reg) - (X_W+1)'(a_xr_reg);
        b_ya = (X_W+1)'(a_za_reg) - (X_W+1)'(b_xa);
        b_sr = S_W'(a_pr_reg) + S_W'(r_r_reg);
        b_sa = S_W'(a_pa_reg) + S_W'(r_a_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_B]) begin
            b_side_reg.r.x     <= a_xr_reg;
            b_side_reg.r.p     <= a_pr_reg;
            b_side_reg.r.neg   <= b_yr[X_W];
            b_side_reg.r.szero <= b_sr == '0;
            b_side_reg.a.x     <= b_xa;
            b_side_reg.a.p     <= a_pa_reg;
            b_side_reg.a.neg   <= b_ya[X_W];
            b_side_reg.a.szero <= b_sa == '0;
            b_side_reg.have    <= a_have_reg;
            b_mag_r_reg        <= MAG_W'(b_yr[X_W] ? -b_yr : b_yr);
            b_mag_a_reg        <= MAG_W'(b_ya[X_W] ? -b_ya : b_ya);
            b_s_r_reg          <= b_sr;
            b_s_a_reg          <= b_sa;
        end
    end

    // ---------------- stage C: products ----------------
    side_t             c_side_reg;
    logic [PROD_W-1:0] c_pc_r_reg, c_pc_a_reg, c_pv_r_reg, c_pv_a_reg;
    logic [S_W-1:0]    c_s_r_reg, c_s_a_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_C]) begin
            c_side_reg <= b_side_reg;
            c_pc_r_reg <= PROD_W'(b_side_reg.r.p) * PROD_W'(b_mag_r_reg);
            c_pc_a_reg <= PROD_W'(b_side_reg.a.p) * PROD_W'(b_mag_a_reg);
            c_pv_r_reg <= PROD_W'(b_side_reg.r.p) * PROD_W'(r_r_reg);
            c_pv_a_reg <= PROD_W'(b_side_reg.a.p) * PROD_W'(r_a_reg);
            c_s_r_reg  <= b_s_r_reg;
            c_s_a_reg  <= b_s_a_reg;
        end
    end

    // ---------------- stage D: add half the divisor for rounding ----------------
    side_t            d_side_reg;
    logic [NUM_W-1:0] d_nc_r_reg, d_nc_a_reg, d_nv_r_reg, d_nv_a_reg;
    logic [S_W-1:0]   d_s_r_reg, d_s_a_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_D]) begin
            d_side_reg <= c_side_reg;
            d_nc_r_reg <= NUM_W'(c_pc_r_reg) + NUM_W'(c_s_r_reg >> 1);
            d_nc_a_reg <= NUM_W'(c_pc_a_reg) + NUM_W'(c_s_a_reg >> 1);
            d_nv_r_reg <= NUM_W'(c_pv_r_reg) + NUM_W'(c_s_r_reg >> 1);
            d_nv_a_reg <= NUM_W'(c_pv_a_reg) + NUM_W'(c_s_a_reg >> 1);
            d_s_r_reg  <= c_s_r_reg;
            d_s_a_reg  <= c_s_a_reg;
        end
    end

    // ---------------- divider stages ----------------
    logic [QUO_W-1:0] qc_r, qc_a, qv_r, qv_a;

    ptku_div #(.NUM_W(NUM_W), .DEN_W(S_W), .Q_W(QUO_W)) u_div_cr (
        .aclk(aclk), .en(en[ST_DV +: QUO_W]), .num(d_nc_r_reg), .den(d_s_r_reg), .quo(qc_r)
    );
    ptku_div #(.NUM_W(NUM_W), .DEN_W(S_W), .Q_W(QUO_W)) u_div_ca (
        .aclk(aclk), .en(en[ST_DV +: QUO_W]), .num(d_nc_a_reg), .den(d_s_a_reg), .quo(qc_a)
    );
    ptku_div #(.NUM_W(NUM_W), .DEN_W(S_W), .Q_W(QUO_W)) u_div_vr (
        .aclk(aclk), .en(en[ST_DV +: QUO_W]), .num(d_nv_r_reg), .den(d_s_r_reg), .quo(qv_r)
    );
    ptku_div #(.NUM_W(NUM_W), .DEN_W(S_W), .Q_W(QUO_W)) u_div_va (
        .aclk(aclk), .en(en[ST_DV +: QUO_W]), .num(d_nv_a_reg), .den(d_s_a_reg), .quo(qv_a)
    );

    // Carry the prediction alongside the dividers
    side_t dv_side_reg [QUO_W];

    always_ff @(posedge aclk) begin
        if (en[ST_DV]) begin
            dv_side_reg[0] <= d_side_reg;
        end
        for (int j = 1; j < QUO_W; j++) begin
            if (en[ST_DV + j]) begin
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    // ---------------- stage E: apply correction, saturate ----------------
    side_t e_in;
    assign e_in = dv_side_reg[QUO_W-1];

    logic [QUO_W-1:0]       e_corr_r, e_corr_a;
    logic signed [X_W+1:0]  e_xr, e_xa;
    logic [P_W-1:0]         e_pr, e_pa;
    logic signed [RNG_W-1:0] e_xr_sat;
    logic signed [ANG_W-1:0] e_xa_sat;
    logic [VAR_W-1:0]       e_pr_sat, e_pa_sat;

    always_comb begin
        // A zero denominator means zero gain and zero variance
        e_corr_r = e_in.r.szero ? '0 : qc_r;
        e_corr_a = e_in.a.szero ? '0 : qc_a;
        e_xr = (X_W+2)'(e_in.r.x);
        e_xa = (X_W+2)'(e_in.a.x);
        e_pr = e_in.r.p;
        e_pa = e_in.a.p;
        if (e_in.have) begin
            e_xr = e_in.r.neg ? e_xr - $signed({2'b00, e_corr_r})
                              : e_xr + $signed({2'b00, e_corr_r});
            e_xa = e_in.a.neg ? e_xa - $signed({2'b00, e_corr_a})
                              : e_xa + $signed({2'b00, e_corr_a});
            e_pr = e_in.r.szero ? '0 : P_W'(qv_r);
            e_pa = e_in.a.szero ? '0 : P_W'(qv_a);
        end
        if (e_xr > (X_W+2)'(RANGE_LIM)) begin
            e_xr_sat = RNG_W'(RANGE_LIM);
        end else if (e_xr < (X_W+2)'(-RANGE_LIM)) begin
            e_xr_sat = RNG_W'(-RANGE_LIM);
        end else begin
            e_xr_sat = RNG_W'(e_xr);
        end
        if (e_xa > (X_W+2)'(ANGLE_LIM)) begin
            e_xa_sat = ANG_W'(ANGLE_LIM);
        end else if (e_xa < (X_W+2)'(-ANGLE_LIM)) begin
            e_xa_sat = ANG_W'(-ANGLE_LIM);
        end else begin
            e_xa_sat = ANG_W'(e_xa);
        end
        e_pr_sat = e_pr[P_W-1] ? '1 : VAR_W'(e_pr);
        e_pa_sat = e_pa[P_W-1] ? '1 : VAR_W'(e_pa);
    end

    logic signed [RNG_W-1:0] e_xr_reg;
    logic signed [ANG_W-1:0] e_xa_reg;
    logic [VAR_W-1:0]        e_pr_reg, e_pa_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_E]) begin
            e_xr_reg <= e_xr_sat;
            e_xa_reg <= e_xa_sat;
            e_pr_reg <= e_pr_sat;
            e_pa_reg <= e_pa_sat;
        end
    end

    // ---------------- stage F: gate check, output register ----------------
    logic signed [RNG_W-1:0] f_xr_reg;
    logic signed [ANG_W-1:0] f_xa_reg;
    logic [VAR_W-1:0]        f_pr_reg, f_pa_reg;
    logic                    f_keep_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_F]) begin
            f_xr_reg   <= e_xr_reg;
            f_xa_reg   <= e_xa_reg;
            f_pr_reg   <= e_pr_reg;
            f_pa_reg   <= e_pa_reg;
            f_keep_reg <= (e_pr_reg < g_r_reg) && (e_pa_reg < g_a_reg);
        end
    end

    assign m_tvalid = vld_reg[ST_F];
    assign m_tdata  = {f_pa_reg, f_pr_reg, f_xa_reg, f_xr_reg};
    assign m_tuser  = f_keep_reg;

`ifndef SYNTHESIS
    // An open sink lets every stage advance, so the input side is never blocked
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    // The keep flag agrees with the delivered variances and the gates
    a_keep_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (f_pr_reg < g_r_reg && f_pa_reg < g_a_reg))
        else $error("keep set with a variance above its gate");

    // Saturation keeps the angle within its limits
    a_angle_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (f_xa_reg <= ANG_W'(ANGLE_LIM) && f_xa_reg >= ANG_W'(-ANGLE_LIM)))
        else $error("post_angle outside its saturation limits");

    // A stage that is full and blocked keeps its valid bit
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_E] && !en[ST_E]) |=> vld_reg[ST_E])
        else $error("track lost from a stalled stage");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ptku_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den * 2**Q_W.
module ptku_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24,
    parameter int Q_W   = 24
) (
    input  wire logic             aclk,
    input  wire logic [Q_W-1:0]   en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   lq_reg  [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];

    logic [DEN_W-1:0] rem_in [Q_W];
    logic [Q_W-1:0]   lq_in  [Q_W];
    logic [DEN_W-1:0] den_in [Q_W];
    logic [DEN_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   lq_next  [Q_W];

    always_comb begin
        rem_in[0] = DEN_W'(num[NUM_W-1:Q_W]);
        lq_in[0]  = num[Q_W-1:0];
        den_in[0] = den;
        for (int j = 1; j < Q_W; j++) begin
            rem_in[j] = rem_reg[j-1];
            lq_in[j]  = lq_reg[j-1];
            den_in[j] = den_reg[j-1];
        end
    end

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            logic [DEN_W:0] trial;
            logic           fits;
            trial = {rem_in[j], lq_in[j][Q_W-1]};
            fits  = trial >= {1'b0, den_in[j]};
            rem_next[j] = fits ? DEN_W'(trial - {1'b0, den_in[j]}) : DEN_W'(trial);
            lq_next[j]  = {lq_in[j][Q_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < Q_W; j++) begin
            if (en[j]) begin
                rem_reg[j] <= rem_next[j];
                lq_reg[j]  <= lq_next[j];
                den_reg[j] <= den_in[j];
            end
        end
    end

    assign quo = lq_reg[Q_W-1];

endmodule

`default_nettype wire
